### hdl/linked_block_chain_allocator_unit_macros.svh
// ----------------------------------------------------------------------------
// Linked block chain allocator assertion macros
// Shared assertion forms for the allocator modules; both sample on clk and
// stay quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LINKED_BLOCK_CHAIN_ALLOCATOR_UNIT_MACROS_SVH
`define LINKED_BLOCK_CHAIN_ALLOCATOR_UNIT_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define LBCA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define LBCA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/lbca_pkg.sv
// ----------------------------------------------------------------------------
// Linked block chain allocator package
// Operation and status codes, entry codes and the command and status groups
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package lbca_pkg;

  // field widths of the stream payload
  localparam int POS_W      = 16;
  localparam int STATUS_W   = 2;
  localparam int FREED_W    = 9;
  localparam int OP_W       = 2;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  // chain table entry codes: free, chain end, link base (link to k is k + base)
  localparam int ENT_FREE      = 0;
  localparam int ENT_END       = 1;
  localparam int ENT_LINK_BASE = 2;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_FREE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_BROKEN = 2'd2
  } status_t;

  // table write port source
  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLR,
    WR_END,
    WR_LINK,
    WR_FREE
  } wr_sel_t;

  // table read address source
  typedef enum logic [1:0] {
    RD_SCAN,
    RD_BLOCK,
    RD_CUR
  } rd_sel_t;

  // result position source
  typedef enum logic [1:0] {
    NX_KEEP,
    NX_INC,
    NX_LINK,
    NX_FOUND
  } next_sel_t;

  typedef struct packed {
    logic      accept;
    logic      load_q;
    logic      scan_init;
    logic      scan_step;
    logic      walk_init;
    rd_sel_t   rd_sel;
    wr_sel_t   wr_sel;
    next_sel_t next_sel;
    logic      set_status;
    status_t   status;
    logic      load_out;
  } lbca_cmd_t;

  typedef struct packed {
    op_t  op;
    logic below;
    logic oob;
    logic boundary;
    logic ent_free;
    logic ent_end;
    logic link_oob;
    logic scan_hit;
    logic scan_none;
    logic clr_last;
  } lbca_stat_t;

endpackage

### hdl/linked_block_chain_allocator_unit.sv
// ----------------------------------------------------------------------------
// Linked block chain allocator
// Pool of equal blocks chained through a table: allocate, advance write and
// read positions, free a chain.
//
//   Channel  Direction  Beat contents
//   in_*     slave      operation, position
//   out_*    master     next_position, status, blocks_freed
//
// An in-block advance needs only the position decode; a boundary read also
// reads the block's table entry. Allocation scans from the lowest possibly
// free block at one entry per cycle; a write extension also writes the link.
// Free reads and clears each block of the chain in turn through the single
// table read port. After reset a clearing pass over every table entry runs
// before the first beat is accepted. A new beat is taken while the last
// result still waits; the block then holds its result until out_tready.
// ----------------------------------------------------------------------------
module linked_block_chain_allocator_unit import lbca_pkg::*; #(
  parameter int NUM_BLOCKS  = 256,
  parameter int BLOCK_SIZE  = 128,
  parameter int BASE_OFFSET = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [1:0] operation, [17:2] position
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // [15:0] next_position, [17:16] status,
                                            // [26:18] blocks_freed
);

  lbca_cmd_t           cmd;
  lbca_stat_t          stat;
  logic [POS_W-1:0]    next_position;
  logic [STATUS_W-1:0] status;
  logic [FREED_W-1:0]  blocks_freed;

  lbca_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  lbca_dpath #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_SIZE  (BLOCK_SIZE),
    .BASE_OFFSET (BASE_OFFSET)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_operation      (in_tdata[OP_W-1:0]),
    .in_position       (in_tdata[OP_W+POS_W-1:OP_W]),
    .cmd               (cmd),
    .stat              (stat),
    .out_next_position (next_position),
    .out_status        (status),
    .out_blocks_freed  (blocks_freed)
  );

  // pack the result beat, pad to whole bytes
  assign out_tdata = {
    (OUT_DATA_W - POS_W - STATUS_W - FREED_W)'(0),
    blocks_freed,
    status,
    next_position
  };

endmodule

### hdl/lbca_dpath.sv
// ----------------------------------------------------------------------------
// Linked block chain allocator datapath
// Chain table memory, position decode, free block scan, chain walk counters
// and the result and output registers.
// ----------------------------------------------------------------------------
module lbca_dpath import lbca_pkg::*; #(
  parameter int NUM_BLOCKS  = 256,
  parameter int BLOCK_SIZE  = 128,
  parameter int BASE_OFFSET = 512
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [OP_W-1:0]     in_operation,
  input  logic [POS_W-1:0]    in_position,
  input  lbca_cmd_t           cmd,
  output lbca_stat_t          stat,
  output logic [POS_W-1:0]    out_next_position,
  output logic [STATUS_W-1:0] out_status,
  output logic [FREED_W-1:0]  out_blocks_freed
);

  localparam int IW = $clog2(NUM_BLOCKS);
  localparam int CW = $clog2(NUM_BLOCKS + 1);
  localparam int EW = $clog2(NUM_BLOCKS + 2);
  localparam int FW = (CW > FREED_W) ? CW : FREED_W;
  localparam int BW = $clog2(BLOCK_SIZE + 1);
  // reciprocal of the block size: exact quotient for any 16-bit dividend
  localparam int DL = $clog2(BLOCK_SIZE);
  localparam int DS = POS_W + DL;
  localparam longint DM = ((longint'(1) << DS) + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int MW = POS_W + 2;
  localparam int PW = POS_W + MW;

  localparam logic [POS_W:0]   BASE_W   = (POS_W + 1)'(BASE_OFFSET);
  localparam logic [POS_W-1:0] BASE_LO  = POS_W'(BASE_OFFSET);
  localparam logic [MW-1:0]    RECIP    = MW'(DM);
  localparam logic [BW-1:0]    BSIZE    = BW'(BLOCK_SIZE);
  localparam logic [POS_W-1:0] LAST_OFS = POS_W'(BLOCK_SIZE - 1);
  localparam logic [POS_W:0]   NB_Q     = (POS_W + 1)'(NUM_BLOCKS);
  localparam logic [CW-1:0]    NB_C     = CW'(NUM_BLOCKS);
  localparam logic [EW-1:0]    NB_E     = EW'(NUM_BLOCKS);
  localparam logic [IW-1:0]    LAST_IDX = IW'(NUM_BLOCKS - 1);
  localparam logic [EW-1:0]    E_FREE   = EW'(ENT_FREE);
  localparam logic [EW-1:0]    E_END    = EW'(ENT_END);
  localparam logic [EW-1:0]    E_LINK   = EW'(ENT_LINK_BASE);

  logic [EW-1:0]       mem [NUM_BLOCKS];
  logic [EW-1:0]       rd_data_r;

  op_t                 op_r;
  logic [POS_W-1:0]    pos_r;
  logic [POS_W-1:0]    q_r;
  logic [IW-1:0]       cur_r;
  logic [IW-1:0]       found_r;
  logic [IW-1:0]       clr_r;
  logic [CW-1:0]       hint_r;
  logic [CW-1:0]       scan_r;
  logic                pend_r;
  logic [FW-1:0]       freed_r;
  logic [POS_W-1:0]    res_next_r;
  status_t             res_status_r;
  logic [POS_W-1:0]    out_next_r;
  status_t             out_status_r;
  logic [FREED_W-1:0]  out_freed_r;

  logic [POS_W-1:0]    rel;
  logic [PW-1:0]       prod;
  logic [POS_W+BW-1:0] qd;
  logic [POS_W-1:0]    blk_ofs;
  logic [IW-1:0]       qidx;
  logic [EW-1:0]       ent_link;
  logic [CW-1:0]       scan_prev;
  logic [IW-1:0]       bs_idx;
  logic [31:0]         bs_sum;
  logic                we;
  logic [IW-1:0]       waddr;
  logic [EW-1:0]       wdata;
  logic [IW-1:0]       raddr;

  // decode position into block index and offset
  assign rel     = pos_r - BASE_LO;
  assign prod    = rel * RECIP;
  assign qd      = q_r * BSIZE;
  assign blk_ofs = rel - qd[POS_W-1:0];
  assign qidx    = q_r[IW-1:0];

  // entry decode and scan bookkeeping
  assign ent_link  = rd_data_r - E_LINK;
  assign scan_prev = scan_r - CW'(1);

  // block start of the linked or freshly found block
  assign bs_idx = (cmd.next_sel == NX_LINK) ? ent_link[IW-1:0] : found_r;
  assign bs_sum = 32'(BASE_OFFSET) + 32'(bs_idx) * 32'(BLOCK_SIZE);

  always_comb begin
    stat.op        = op_r;
    stat.below     = {1'b0, pos_r} < BASE_W;
    stat.oob       = {1'b0, q_r} >= NB_Q;
    stat.boundary  = (blk_ofs == LAST_OFS);
    stat.ent_free  = (rd_data_r == E_FREE);
    stat.ent_end   = (rd_data_r == E_END);
    stat.link_oob  = (ent_link >= NB_E);
    stat.scan_hit  = pend_r && (rd_data_r == E_FREE);
    stat.scan_none = !stat.scan_hit && (scan_r == NB_C);
    stat.clr_last  = (clr_r == LAST_IDX);
  end

  // select the table write
  always_comb begin
    we    = 1'b1;
    waddr = cur_r;
    wdata = E_FREE;
    unique case (cmd.wr_sel)
      WR_CLR: begin
        waddr = clr_r;
      end
      WR_END: begin
        waddr = found_r;
        wdata = E_END;
      end
      WR_LINK: begin
        waddr = qidx;
        wdata = EW'(found_r) + E_LINK;
      end
      WR_FREE: begin
        waddr = cur_r;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // select the table read
  always_comb begin
    unique case (cmd.rd_sel)
      RD_BLOCK: raddr = qidx;
      RD_CUR:   raddr = cur_r;
      default:  raddr = scan_r[IW-1:0];
    endcase
  end

  // chain table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  // control counters: clear sweep, free hint, scan pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r  <= '0;
      hint_r <= '0;
      scan_r <= '0;
      pend_r <= 1'b0;
    end else begin
      if (cmd.wr_sel == WR_CLR) begin
        clr_r <= clr_r + IW'(1);
      end
      if (cmd.wr_sel == WR_END) begin
        hint_r <= CW'(found_r) + CW'(1);
      end else if (cmd.wr_sel == WR_FREE && CW'(cur_r) < hint_r) begin
        hint_r <= CW'(cur_r);
      end
      if (cmd.scan_init) begin
        scan_r <= hint_r;
        pend_r <= 1'b0;
      end else if (cmd.scan_step && !stat.scan_hit && !stat.scan_none) begin
        scan_r <= scan_r + CW'(1);
        pend_r <= 1'b1;
      end
    end
  end

  // operands, walk state and result
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r         <= op_t'(in_operation);
      pos_r        <= in_position;
      res_next_r   <= '0;
      res_status_r <= ST_OK;
      freed_r      <= '0;
    end else begin
      if (cmd.wr_sel == WR_FREE) begin
        freed_r <= freed_r + FW'(1);
      end
      if (cmd.set_status) begin
        res_status_r <= cmd.status;
      end
      unique case (cmd.next_sel)
        NX_INC:            res_next_r <= pos_r + POS_W'(1);
        NX_LINK, NX_FOUND: res_next_r <= bs_sum[POS_W-1:0];
        default:           res_next_r <= res_next_r;
      endcase
    end
    if (cmd.load_q) begin
      q_r <= POS_W'(prod >> DS);
    end
    if (cmd.walk_init) begin
      cur_r <= qidx;
    end else if (cmd.wr_sel == WR_FREE) begin
      cur_r <= ent_link[IW-1:0];
    end
    if (cmd.scan_step && stat.scan_hit) begin
      found_r <= scan_prev[IW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_next_r   <= res_next_r;
      out_status_r <= res_status_r;
      out_freed_r  <= freed_r[FREED_W-1:0];
    end
  end

  assign out_next_position = out_next_r;
  assign out_status        = out_status_r;
  assign out_blocks_freed  = out_freed_r;

endmodule

### hdl/lbca_ctrl.sv
// ----------------------------------------------------------------------------
// Linked block chain allocator controller
// Sequences the table clear, position decode, entry reads, free block scan,
// chain walk and the output handshake.
// ----------------------------------------------------------------------------
`include "linked_block_chain_allocator_unit_macros.svh"

module lbca_ctrl import lbca_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  lbca_stat_t stat,
  output lbca_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOC,
    S_CHK,
    S_ENT,
    S_SCAN,
    S_MARK,
    S_LINK,
    S_WRD,
    S_WENT,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    cmd            = '0;
    cmd.rd_sel     = RD_SCAN;
    cmd.wr_sel     = WR_NONE;
    cmd.next_sel   = NX_KEEP;
    cmd.status     = ST_OK;
    unique case (state_r)
      S_CLEAR: begin
        cmd.wr_sel = WR_CLR;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_LOC;
        end
      end
      S_LOC: begin
        cmd.load_q = 1'b1;
        if (stat.op == OP_ALLOC) begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end else begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        priority if (stat.below || stat.oob) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_BROKEN;
          state_nxt      = S_FINISH;
        end else if (stat.op == OP_FREE) begin
          cmd.walk_init = 1'b1;
          state_nxt     = S_WRD;
        end else if (!stat.boundary) begin
          cmd.next_sel = NX_INC;
          state_nxt    = S_FINISH;
        end else begin
          cmd.rd_sel = RD_BLOCK;
          state_nxt  = S_ENT;
        end
      end
      S_ENT: begin
        priority if (!stat.ent_free && !stat.ent_end) begin
          cmd.next_sel = NX_LINK;
          state_nxt    = S_FINISH;
        end else if (stat.ent_end && stat.op == OP_WRITE) begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end else begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_BROKEN;
          state_nxt      = S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        priority if (stat.scan_hit) begin
          state_nxt = S_MARK;
        end else if (stat.scan_none) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_NOFREE;
          state_nxt      = S_FINISH;
        end
      end
      S_MARK: begin
        cmd.wr_sel   = WR_END;
        cmd.next_sel = NX_FOUND;
        state_nxt    = (stat.op == OP_WRITE) ? S_LINK : S_FINISH;
      end
      S_LINK: begin
        cmd.wr_sel = WR_LINK;
        state_nxt  = S_FINISH;
      end
      S_WRD: begin
        cmd.rd_sel = RD_CUR;
        state_nxt  = S_WENT;
      end
      S_WENT: begin
        priority if (stat.ent_free) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_BROKEN;
          state_nxt      = S_FINISH;
        end else if (stat.ent_end) begin
          cmd.wr_sel = WR_FREE;
          state_nxt  = S_FINISH;
        end else if (stat.link_oob) begin
          cmd.wr_sel     = WR_FREE;
          cmd.set_status = 1'b1;
          cmd.status     = ST_BROKEN;
          state_nxt      = S_FINISH;
        end else begin
          cmd.wr_sel = WR_FREE;
          state_nxt  = S_WRD;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `LBCA_ASSERT_NEXT(a_one_item, in_tvalid && in_tready, !in_tready, "second beat accepted while busy")
  `LBCA_ASSERT_SAME(a_out_slot, cmd.load_out, !out_valid_r || out_tready, "result overwrote a pending beat")
  `LBCA_ASSERT_SAME(a_link_order, cmd.wr_sel == WR_LINK, $past(state_r) == S_MARK, "link written without fresh block")

endmodule

### test/tb_linked_block_chain_allocator_unit.sv
// ----------------------------------------------------------------------------
// Linked block chain allocator testbench
// Streams allocate, write advance, read advance and free beats into the
// allocator and checks every result beat against an in-bench model of the
// chain table. A directed opening covers pool edges and broken chains, then
// state-aware random batches grow, walk and free chains, with one pass that
// chains the whole pool together. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_linked_block_chain_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import lbca_pkg::*;

  localparam int NUM_BLOCKS  = 256;
  localparam int BLOCK_SIZE  = 128;
  localparam int BASE_OFFSET = 512;
  localparam int POOL_END    = BASE_OFFSET + NUM_BLOCKS * BLOCK_SIZE;
  localparam int RANDOM_BEATS = 850;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    op_t         op;
    logic [15:0] pos;
  } alloc_req_t;

  typedef struct {
    logic [15:0] next_pos;
    status_t     status;
    logic [8:0]  freed;
  } outcome_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [1:0] operation, [17:2] position
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // [15:0] next_position, [17:16] status,
                                          // [26:18] blocks_freed

  // model of the chain table: 0 free, 1 chain end, k + 2 link to block k
  int unsigned chain_tbl [NUM_BLOCKS];

  alloc_req_t req_q[$];
  outcome_t   outcome_q[$];
  alloc_req_t cur_req;
  outcome_t   head_outcome;

  int   err_cnt = 0;
  int   planned = 0;
  int   cyc = 0;
  int   op_cnt [4];
  int   status_cnt [3];
  int   max_freed = 0;
  logic calm;

  // no stalls for a quarter of every long window
  assign calm = (cyc % 16384) >= 12288;

  linked_block_chain_allocator_unit #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .BLOCK_SIZE (BLOCK_SIZE),
    .BASE_OFFSET(BASE_OFFSET)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #2 clk = ~clk;

  function automatic logic [15:0] block_pos(int idx);
    return 16'(BASE_OFFSET + idx * BLOCK_SIZE);
  endfunction

  function automatic logic [15:0] last_pos(int idx);
    return block_pos(idx) + 16'(BLOCK_SIZE - 1);
  endfunction

  function automatic int lowest_free();
    for (int i = 0; i < NUM_BLOCKS; i++)
      if (chain_tbl[i] == ENT_FREE) return i;
    return -1;
  endfunction

  function automatic int used_blocks();
    int n;
    n = 0;
    for (int i = 0; i < NUM_BLOCKS; i++)
      if (chain_tbl[i] != ENT_FREE) n++;
    return n;
  endfunction

  // random block in use, -1 when the pool is empty
  function automatic int pick_used();
    int start;
    start = $urandom_range(NUM_BLOCKS - 1);
    for (int i = 0; i < NUM_BLOCKS; i++)
      if (chain_tbl[(start + i) % NUM_BLOCKS] != ENT_FREE) return (start + i) % NUM_BLOCKS;
    return -1;
  endfunction

  // follow links backward to a block nothing points at
  function automatic int chain_head(int blk);
    int cur, prev;
    cur = blk;
    for (int s = 0; s < NUM_BLOCKS; s++) begin
      prev = -1;
      for (int i = 0; i < NUM_BLOCKS; i++)
        if (prev < 0 && chain_tbl[i] == cur + ENT_LINK_BASE) prev = i;
      if (prev < 0) return cur;
      cur = prev;
    end
    return cur;
  endfunction

  // chain end reached from blk, -1 when the chain is broken
  function automatic int chain_tail(int blk);
    int cur;
    int unsigned ent;
    cur = blk;
    for (int s = 0; s < NUM_BLOCKS; s++) begin
      ent = chain_tbl[cur];
      if (ent == ENT_END) return cur;
      if (ent == ENT_FREE || ent - ENT_LINK_BASE >= NUM_BLOCKS) return -1;
      cur = ent - ENT_LINK_BASE;
    end
    return -1;
  endfunction

  // apply one request to the table model and return the result it yields
  function automatic outcome_t resolve_request(op_t op, logic [15:0] pos);
    outcome_t    o;
    int          p, blk, offs, cur, fresh, steps;
    int unsigned ent;
    logic        walking;
    o.next_pos = '0;
    o.status   = ST_OK;
    o.freed    = '0;
    p = pos;
    if (op == OP_ALLOC) begin
      fresh = lowest_free();
      if (fresh < 0) begin
        o.status = ST_NOFREE;
      end else begin
        chain_tbl[fresh] = ENT_END;
        o.next_pos = block_pos(fresh);
      end
    end else if (p < BASE_OFFSET || (p - BASE_OFFSET) / BLOCK_SIZE >= NUM_BLOCKS) begin
      o.status = ST_BROKEN;
    end else begin
      blk  = (p - BASE_OFFSET) / BLOCK_SIZE;
      offs = (p - BASE_OFFSET) % BLOCK_SIZE;
      if (op != OP_FREE) begin
        ent = chain_tbl[blk];
        if (offs + 1 < BLOCK_SIZE) begin
          o.next_pos = pos + 16'd1;
        end else if (ent >= ENT_LINK_BASE) begin
          o.next_pos = block_pos(ent - ENT_LINK_BASE);
        end else if (ent == ENT_END && op == OP_WRITE) begin
          // extend the chain with the lowest free block
          fresh = lowest_free();
          if (fresh < 0) begin
            o.status = ST_NOFREE;
          end else begin
            chain_tbl[fresh] = ENT_END;
            chain_tbl[blk]   = fresh + ENT_LINK_BASE;
            o.next_pos = block_pos(fresh);
          end
        end else begin
          o.status = ST_BROKEN;
        end
      end else begin
        // release the chain; a free entry on the way ends the walk as broken
        o.status = ST_BROKEN;
        cur      = blk;
        steps    = 0;
        walking  = 1'b1;
        while (walking && steps < NUM_BLOCKS) begin
          ent = chain_tbl[cur];
          if (ent == ENT_FREE) begin
            walking = 1'b0;
          end else begin
            chain_tbl[cur] = ENT_FREE;
            o.freed = o.freed + 9'd1;
            if (ent == ENT_END) begin
              o.status = ST_OK;
              walking  = 1'b0;
            end else begin
              cur = ent - ENT_LINK_BASE;
              if (cur >= NUM_BLOCKS) walking = 1'b0;
            end
          end
          steps++;
        end
      end
    end
    return o;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  task automatic push_req(op_t op, logic [15:0] pos);
    alloc_req_t r;
    r.op  = op;
    r.pos = pos;
    req_q.push_back(r);
    planned++;
  endtask

  // wait until every queued beat is taken and every result has come back
  task automatic wait_quiet();
    @(negedge clk);
    while (req_q.size() != 0 || in_tvalid || outcome_q.size() != 0) @(negedge clk);
  endtask

  // input driver: predict at accept, then present the next beat or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        outcome_q.push_back(resolve_request(cur_req.op, cur_req.pos));
        op_cnt[cur_req.op]++;
      end
      if (!in_tvalid || in_tready) begin
        if (req_q.size() != 0 && (calm || $urandom_range(99) >= 22)) begin
          cur_req = req_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {6'b0, cur_req.pos, cur_req.op};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor: stall at random, compare each beat with the oldest outcome
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      cyc        <= 0;
    end else begin
      cyc        <= cyc + 1;
      out_tready <= calm || ($urandom_range(99) >= 22);
      if (out_tvalid && out_tready) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: result beat with nothing outstanding, expected none, got %0h",
                   $time, out_tdata);
          err_cnt++;
        end else begin
          head_outcome = outcome_q.pop_front();
          check_field("next_position", head_outcome.next_pos, out_tdata[15:0]);
          check_field("status", head_outcome.status, out_tdata[17:16]);
          check_field("blocks_freed", head_outcome.freed, out_tdata[26:18]);
          status_cnt[head_outcome.status]++;
          if (head_outcome.freed > max_freed) max_freed = head_outcome.freed;
        end
      end
    end
  end

  // stimulus
  initial begin
    int   kind, b, t, h, j, cur, n;
    logic [15:0] pos;
    logic long_done;
    long_done = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: pool edges, link following, extension and broken chains
    push_req(OP_ALLOC, 16'h0000);
    push_req(OP_ALLOC, 16'hFFFF);
    push_req(OP_WRITE, block_pos(0));
    push_req(OP_WRITE, last_pos(0));
    push_req(OP_WRITE, last_pos(0));
    push_req(OP_READ, last_pos(0));
    push_req(OP_READ, last_pos(2));
    push_req(OP_READ, last_pos(3));
    push_req(OP_WRITE, last_pos(3));
    push_req(OP_READ, block_pos(1) + 16'd60);
    push_req(OP_WRITE, last_pos(NUM_BLOCKS - 1) - 16'd1);
    push_req(OP_READ, last_pos(NUM_BLOCKS - 1));
    push_req(OP_WRITE, 16'h0000);
    push_req(OP_READ, 16'(BASE_OFFSET - 1));
    push_req(OP_FREE, 16'(POOL_END));
    push_req(OP_WRITE, 16'hFFFF);
    push_req(OP_FREE, block_pos(0) + 16'd88);
    push_req(OP_FREE, block_pos(0) + 16'd88);
    push_req(OP_ALLOC, 16'h5A5A);
    push_req(OP_WRITE, last_pos(0));
    push_req(OP_FREE, block_pos(2) + 16'd32);
    push_req(OP_FREE, block_pos(0));
    push_req(OP_FREE, block_pos(1));
    push_req(OP_ALLOC, 16'h0000);
    n = planned;

    // random batches planned from the settled table state
    while (planned < n + RANDOM_BEATS) begin
      wait_quiet();
      if (!long_done && planned >= n + 300) begin
        // empty the pool, then chain every block into one run
        while (used_blocks() > 0) begin
          push_req(OP_FREE, block_pos(chain_head(pick_used())) +
                   16'($urandom_range(BLOCK_SIZE - 1)));
          wait_quiet();
        end
        push_req(OP_ALLOC, 16'($urandom));
        for (int k = 0; k < NUM_BLOCKS; k++) push_req(OP_WRITE, last_pos(k));
        push_req(OP_ALLOC, 16'($urandom));
        repeat (8) push_req(OP_READ, last_pos($urandom_range(NUM_BLOCKS - 2)));
        push_req(OP_FREE, block_pos(0) + 16'($urandom_range(BLOCK_SIZE - 1)));
        long_done = 1'b1;
      end else begin
        kind = $urandom_range(99);
        if (used_blocks() > NUM_BLOCKS * 3 / 4) kind = 65;
        b = pick_used();
        if (b < 0 && kind < 75) kind = 80;
        if (kind < 25) begin
          // grow a chain at its end
          t = chain_tail(b);
          if (t < 0) t = b;
          if ($urandom_range(3) == 0)
            push_req(OP_WRITE, block_pos(t) + 16'($urandom_range(BLOCK_SIZE - 2)));
          push_req(OP_WRITE, last_pos(t));
        end else if (kind < 45) begin
          // walk a chain with reads across its block boundaries
          h = chain_head(b);
          push_req(OP_READ, block_pos(h) + 16'($urandom_range(BLOCK_SIZE - 2)));
          cur = h;
          j = $urandom_range(1, 6);
          while (j > 0) begin
            push_req(OP_READ, last_pos(cur));
            if (chain_tbl[cur] >= ENT_LINK_BASE &&
                chain_tbl[cur] - ENT_LINK_BASE < NUM_BLOCKS) begin
              cur = chain_tbl[cur] - ENT_LINK_BASE;
              j--;
            end else begin
              j = 0;
            end
          end
        end else if (kind < 60) begin
          // write across a boundary somewhere inside a chain
          push_req(OP_WRITE, last_pos(b));
          if ($urandom_range(1) == 0)
            push_req(OP_WRITE, block_pos(b) + 16'($urandom_range(BLOCK_SIZE - 1)));
        end else if (kind < 75) begin
          // free from the head, now and then from the middle
          h = ($urandom_range(3) == 0) ? b : chain_head(b);
          push_req(OP_FREE, block_pos(h) + 16'($urandom_range(BLOCK_SIZE - 1)));
        end else if (kind < 85) begin
          repeat ($urandom_range(1, 4)) push_req(OP_ALLOC, 16'($urandom));
        end else begin
          // noise: any operation at full-range or edge positions
          repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(3))
              0:       pos = 16'($urandom);
              1:       pos = 16'(BASE_OFFSET - 1 + $urandom_range(1));
              2:       pos = 16'(POOL_END - 1 + $urandom_range(1));
              default: pos = last_pos($urandom_range(NUM_BLOCKS - 1));
            endcase
            push_req(op_t'($urandom_range(3)), pos);
          end
        end
      end
    end

    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d beats: %0d allocate, %0d write advance, %0d read advance, %0d free.",
             planned, op_cnt[OP_ALLOC], op_cnt[OP_WRITE], op_cnt[OP_READ], op_cnt[OP_FREE]);
    $display("Results: %0d ok, %0d pool full, %0d broken chain; longest release %0d blocks.",
             status_cnt[ST_OK], status_cnt[ST_NOFREE], status_cnt[ST_BROKEN], max_freed);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #12_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, outcome_q.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
